[src/bfnd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and codes of the bilevel frame downscaler.
// No dependencies; imported by every module of the block except bfnd_ram.
package bfnd_pkg;

  // Frame store geometry
  localparam int BYTES_PER_ROW = 48;
  localparam int MAX_ROWS      = 512;
  localparam int STORE_BYTES   = BYTES_PER_ROW * MAX_ROWS;
  localparam int STORE_AW      = $clog2(STORE_BYTES);
  // Computed byte address: row below 1024, column byte below 64
  localparam int BADDR_W       = $clog2(1024 * BYTES_PER_ROW + 64);

  // Shared divider: widest dividend is out_y * src_height
  localparam int DIV_DVD_W = 19;
  localparam int DIV_DSR_W = 11;
  localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_SRC_WIDTH      = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_MAX_OUT_HEIGHT = 2'd2;

  // Commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [7:0] GRAY_BLACK = 8'd0;
  localparam logic [7:0] GRAY_WHITE = 8'd255;

  typedef struct packed {
    logic       command;
    logic [14:0] byte_address;
    logic [7:0]  byte_value;
    logic [8:0]  out_x;
    logic [8:0]  out_y;
  } bfnd_in_t;

  typedef struct packed {
    logic [7:0] gray;
    logic [8:0] out_width;
    logic [9:0] out_height;
    logic       outside;
  } bfnd_out_t;

  typedef struct packed {
    logic [8:0] src_width;
    logic [9:0] src_height;
    logic [9:0] max_out_height;
  } bfnd_cfg_t;

  typedef enum logic [2:0] {
    OP_SCALE,
    OP_WIDTH,
    OP_HEIGHT,
    OP_COLX,
    OP_ROWY
  } bfnd_op_t;

  typedef struct packed {
    logic     load_item;
    logic     wr_byte;
    logic     div_start;
    bfnd_op_t div_op;
    logic     div_take;
    logic     take_outside;
    logic     mem_read;
    logic     take_pixel;
  } bfnd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic outside;
  } bfnd_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_WIDTH_GO,
    ST_WIDTH_WAIT,
    ST_HEIGHT_GO,
    ST_HEIGHT_WAIT,
    ST_CHECK,
    ST_COLX_GO,
    ST_COLX_WAIT,
    ST_ROWY_GO,
    ST_ROWY_WAIT,
    ST_READ,
    ST_FETCH,
    ST_REPLY
  } bfnd_state_t;

endpackage

[src/bfnd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bfnd_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bfnd_pkg for operand widths.
module bfnd_div
  import bfnd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DSR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DSR_W-1:0] rem;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_DSR_W-1:0] dsr;
  logic [DIV_DSR_W:0]   shifted;
  logic [DIV_DSR_W:0]   diff;
  logic                 ge;

  assign shifted = {rem, quo[DIV_DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == DIV_CNT_W'(DIV_DVD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (run) begin
      rem <= ge ? diff[DIV_DSR_W-1:0] : shifted[DIV_DSR_W-1:0];
      quo <= {quo[DIV_DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

[src/bfnd_dp.sv]
`timescale 1ns / 1ps
// Datapath: operand registers, shared divider, frame store and result word.
// Depends on bfnd_pkg, bfnd_div and bfnd_ram.
module bfnd_dp
  import bfnd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bfnd_cfg_t cfg,
  input  bfnd_in_t  item,
  input  bfnd_cmd_t cmd,
  output bfnd_sts_t sts,
  output bfnd_out_t result
);

  logic [8:0]  ox_q;
  logic [8:0]  oy_q;
  logic [10:0] scale_q;
  logic [8:0]  dw_q;
  logic [9:0]  dh_q;
  logic [8:0]  sx_q;
  logic [9:0]  sy_q;
  logic        in_range_q;
  logic [7:0]  gray_q;

  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DSR_W-1:0] dsr;
  logic                 div_done;
  logic [DIV_DVD_W-1:0] quo;
  logic [8:0]           w_rnd;
  logic [9:0]           h_rnd;
  logic [BADDR_W-1:0]   baddr;
  logic                 wr_ok;
  logic [7:0]           rdata;

  bfnd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

  // Operand select; products are registered by the divider at start
  always_comb begin
    unique case (cmd.div_op)
      OP_SCALE: begin
        dvd = DIV_DVD_W'(cfg.src_height);
        dsr = DIV_DSR_W'(cfg.max_out_height) + DIV_DSR_W'(1);
      end
      OP_WIDTH: begin
        dvd = DIV_DVD_W'(cfg.src_width);
        dsr = scale_q;
      end
      OP_HEIGHT: begin
        dvd = DIV_DVD_W'(cfg.src_height);
        dsr = scale_q;
      end
      OP_COLX: begin
        dvd = DIV_DVD_W'(ox_q) * DIV_DVD_W'(cfg.src_width);
        dsr = DIV_DSR_W'(dw_q);
      end
      OP_ROWY: begin
        dvd = DIV_DVD_W'(oy_q) * DIV_DVD_W'(cfg.src_height);
        dsr = DIV_DSR_W'(dh_q);
      end
      default: begin
        dvd = '0;
        dsr = DIV_DSR_W'(1);
      end
    endcase
  end

  // Round down to a multiple of eight, never below eight
  assign w_rnd = (quo[8:3] == '0) ? 9'd8 : {quo[8:3], 3'b000};
  assign h_rnd = (quo[9:3] == '0) ? 10'd8 : {quo[9:3], 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ox_q <= item.out_x;
      oy_q <= item.out_y;
    end
    if (cmd.div_take) begin
      unique case (cmd.div_op)
        OP_SCALE:  scale_q <= 11'(quo[9:0]) + 11'd1;
        OP_WIDTH:  dw_q <= w_rnd;
        OP_HEIGHT: dh_q <= h_rnd;
        OP_COLX: begin
          if (quo >= DIV_DVD_W'(cfg.src_width)) begin
            sx_q <= (cfg.src_width == '0) ? 9'd0 : cfg.src_width - 9'd1;
          end else begin
            sx_q <= quo[8:0];
          end
        end
        OP_ROWY: begin
          if (quo >= DIV_DVD_W'(cfg.src_height)) begin
            sy_q <= (cfg.src_height == '0) ? 10'd0 : cfg.src_height - 10'd1;
          end else begin
            sy_q <= quo[9:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.mem_read) begin
      in_range_q <= 32'(baddr) < 32'(STORE_BYTES);
    end
    if (cmd.take_outside) begin
      gray_q <= GRAY_BLACK;
    end else if (cmd.take_pixel) begin
      gray_q <= (in_range_q && rdata[3'd7 - sx_q[2:0]]) ? GRAY_BLACK : GRAY_WHITE;
    end
  end

  assign baddr = BADDR_W'(sy_q) * BADDR_W'(BYTES_PER_ROW) + BADDR_W'(sx_q[8:3]);
  assign wr_ok = cmd.wr_byte && (32'(item.byte_address) < 32'(STORE_BYTES));

  bfnd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (STORE_AW'(item.byte_address)),
    .wdata (item.byte_value),
    .re    (cmd.mem_read),
    .raddr (STORE_AW'(baddr)),
    .rdata (rdata)
  );

  assign sts.div_done = div_done;
  assign sts.outside  = (ox_q >= dw_q) || ({1'b0, oy_q} >= dh_q);

  assign result.gray       = gray_q;
  assign result.out_width  = dw_q;
  assign result.out_height = dh_q;
  assign result.outside    = sts.outside;

endmodule

[src/bfnd_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences divisions, store read and result strobe.
// Depends on bfnd_pkg.
module bfnd_ctrl
  import bfnd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      command,
  input  logic      cfg_wr,
  input  bfnd_sts_t sts,
  output bfnd_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  bfnd_state_t state, state_next;
  logic        dims_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output size depends only on configuration: keep it until the next write
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      dims_valid <= 1'b0;
    end else if (state == ST_HEIGHT_WAIT && sts.div_done) begin
      dims_valid <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && command == CMD_SAMPLE) begin
          state_next = dims_valid ? ST_CHECK : ST_SCALE_GO;
        end
      end
      ST_SCALE_GO:    state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT:  if (sts.div_done) state_next = ST_WIDTH_GO;
      ST_WIDTH_GO:    state_next = ST_WIDTH_WAIT;
      ST_WIDTH_WAIT:  if (sts.div_done) state_next = ST_HEIGHT_GO;
      ST_HEIGHT_GO:   state_next = ST_HEIGHT_WAIT;
      ST_HEIGHT_WAIT: if (sts.div_done) state_next = ST_CHECK;
      ST_CHECK:       state_next = sts.outside ? ST_REPLY : ST_COLX_GO;
      ST_COLX_GO:     state_next = ST_COLX_WAIT;
      ST_COLX_WAIT:   if (sts.div_done) state_next = ST_ROWY_GO;
      ST_ROWY_GO:     state_next = ST_ROWY_WAIT;
      ST_ROWY_WAIT:   if (sts.div_done) state_next = ST_READ;
      ST_READ:        state_next = ST_FETCH;
      ST_FETCH:       state_next = ST_REPLY;
      ST_REPLY:       state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_op = OP_SCALE;
    busy = (state != ST_IDLE);
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_item = start && command == CMD_SAMPLE;
        cmd.wr_byte   = start && command == CMD_WRITE;
      end
      ST_SCALE_GO: begin
        cmd.div_op    = OP_SCALE;
        cmd.div_start = 1'b1;
      end
      ST_SCALE_WAIT: begin
        cmd.div_op   = OP_SCALE;
        cmd.div_take = sts.div_done;
      end
      ST_WIDTH_GO: begin
        cmd.div_op    = OP_WIDTH;
        cmd.div_start = 1'b1;
      end
      ST_WIDTH_WAIT: begin
        cmd.div_op   = OP_WIDTH;
        cmd.div_take = sts.div_done;
      end
      ST_HEIGHT_GO: begin
        cmd.div_op    = OP_HEIGHT;
        cmd.div_start = 1'b1;
      end
      ST_HEIGHT_WAIT: begin
        cmd.div_op   = OP_HEIGHT;
        cmd.div_take = sts.div_done;
      end
      ST_CHECK: cmd.take_outside = sts.outside;
      ST_COLX_GO: begin
        cmd.div_op    = OP_COLX;
        cmd.div_start = 1'b1;
      end
      ST_COLX_WAIT: begin
        cmd.div_op   = OP_COLX;
        cmd.div_take = sts.div_done;
      end
      ST_ROWY_GO: begin
        cmd.div_op    = OP_ROWY;
        cmd.div_start = 1'b1;
      end
      ST_ROWY_WAIT: begin
        cmd.div_op   = OP_ROWY;
        cmd.div_take = sts.div_done;
      end
      ST_READ:  cmd.mem_read = 1'b1;
      ST_FETCH: cmd.take_pixel = 1'b1;
      ST_REPLY: done = 1'b1;
      default: ;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_WRITE) |=> !busy)
    else $error("byte write left the block busy");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_SAMPLE) |=> busy)
    else $error("sample accepted without going busy");

  a_check_dims: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> dims_valid)
    else $error("bounds check before output size is known");

  a_take_on_done: assert property (@(posedge clk) disable iff (rst)
    cmd.div_take |-> sts.div_done)
    else $error("quotient taken before division finished");

endmodule

[src/bilevel_frame_nearest_downscaler_top.sv]
`timescale 1ns / 1ps
// Top level of the bilevel frame nearest-neighbor downscaler.
// Depends on bfnd_pkg, bfnd_ctrl and bfnd_dp (which holds bfnd_div, bfnd_ram).
//
// Usage:
//   Input words are offered on item with start; a word is accepted at an edge
//   where start is high and busy is low. Command write stores one packed frame
//   byte (MSB leftmost, 1 = black) and produces no result; busy
//   stays low, so writes can stream one per cycle. Command sample returns one
//   result word on result, marked by done for exactly one cycle.
//   Sample sequence: the output size (scale, width, height) takes three passes
//   of the shared bit-serial divider and is cached until the next register
//   write. A sample inside the output then takes two more divisions (column
//   and row mapping) plus a store read before done. A sample beyond the output
//   size skips those divisions and the read and is answered after the bounds
//   check (plus the size passes if not cached). The divider produces 19
//   quotient bits at one bit per cycle.
//   The receiver cannot stall: each result is valid only in its done cycle.
//   Registers are written over the APB port; the user must write them only while the block is idle (not enforced).
//   Reset (synchronous, active high) restores register defaults and returns
//   the controller to idle; frame contents are undefined until written.
module bilevel_frame_nearest_downscaler_top
  import bfnd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  bfnd_in_t           item,
  // result channel
  output logic               done,
  output bfnd_out_t          result,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bfnd_cfg_t cfg;
  logic      cfg_wr;
  bfnd_cmd_t cmd;
  bfnd_sts_t sts;

  // Register file: write on the APB access phase, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width      <= 9'd384;
      cfg.src_height     <= 10'd512;
      cfg.max_out_height <= 10'd300;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SRC_WIDTH:      cfg.src_width      <= pwdata[8:0];
        REG_SRC_HEIGHT:     cfg.src_height     <= pwdata[9:0];
        REG_MAX_OUT_HEIGHT: cfg.max_out_height <= pwdata[9:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Read back: unused addresses return zero
  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_WIDTH:      prdata = 32'(cfg.src_width);
      REG_SRC_HEIGHT:     prdata = 32'(cfg.src_height);
      REG_MAX_OUT_HEIGHT: prdata = 32'(cfg.max_out_height);
      default:            prdata = '0;
    endcase
  end

  // Controller: sequences the shared divider and the frame store read
  bfnd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .cfg_wr  (cfg_wr),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  // Datapath: holds the frame, the operands and the result word
  bfnd_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule
